### sv/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, round constants, initial hash values and the SHA-256 mixing
// functions.
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int unsigned BLK_BITS = 512;
    localparam int unsigned QDEPTH   = 2;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLK_END    = 6'd63;
    localparam logic [2:0] WORD_END   = 3'd7;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MARK,
        F_FILL,
        F_LEN
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ROUND,
        B_ADD,
        B_OUT
    } back_state_t;

    // One 64-byte block, first message byte in the top bits.
    typedef struct packed {
        logic                  msg_end;
        logic [BLK_BITS-1:0]   data;
    } blk_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

### sv/shs_front.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher front end
// Shifts message bytes into a block register, counts message bits, appends
// marker, zero fill and length at end of message, and pushes full blocks.
// ----------------------------------------------------------------------------
module shs_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] data_byte
    input  logic             s_tuser,   // [0] has_byte
    input  logic             s_tlast,   // is_last
    output logic             push,
    output shs_pkg::blk_t    push_blk,
    input  logic             q_full
);
    import shs_pkg::*;

    front_state_t          state_reg, state_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic [63:0]           bitcnt_reg;
    logic [BLK_BITS-1:0]   blk_reg;

    logic                  stall;
    logic                  accept;
    logic                  shift_en;
    logic [7:0]            shift_byte;
    logic [7:0]            len_byte;

    // a shift that completes a block needs room in the queue
    assign stall    = (cnt_reg == BLK_END) && q_full;
    assign accept   = s_tvalid && s_tready;
    assign cnt_next = shift_en ? cnt_reg + 6'd1 : cnt_reg;
    assign len_byte = bitcnt_reg[{3'd7 - cnt_reg[2:0], 3'b000} +: 8];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && s_tlast)
                    state_next = F_MARK;
            end
            F_MARK, F_FILL:
            begin
                if (shift_en)
                    state_next = (cnt_next == LEN_POS) ? F_LEN : F_FILL;
            end
            F_LEN:
            begin
                if (shift_en && cnt_reg == BLK_END)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        shift_en   = 1'b0;
        shift_byte = 8'h00;
        unique case (state_reg)
            F_IDLE:
            begin
                s_tready   = !stall;
                shift_en   = accept && s_tuser;
                shift_byte = s_tdata;
            end
            F_MARK:
            begin
                shift_en   = !stall;
                shift_byte = PAD_MARKER;
            end
            F_FILL:
            begin
                shift_en   = !stall;
                shift_byte = 8'h00;
            end
            F_LEN:
            begin
                shift_en   = !stall;
                shift_byte = len_byte;
            end
            default:
            begin
                shift_en   = 1'b0;
            end
        endcase
    end

    assign push             = shift_en && (cnt_reg == BLK_END);
    assign push_blk.msg_end = (state_reg == F_LEN);
    assign push_blk.data    = {blk_reg[BLK_BITS-9:0], shift_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            cnt_reg    <= '0;
            bitcnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == F_IDLE && accept && s_tuser)
                bitcnt_reg <= bitcnt_reg + 64'd8;
            else if (push && state_reg == F_LEN)
                bitcnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
            blk_reg <= push_blk.data;
    end

    // length bytes only ever fill the last eight places of a block
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_LEN) |-> (cnt_reg >= LEN_POS))
        else $error("length byte outside the tail of the block");

endmodule

### sv/shs_blkq.sv
// ----------------------------------------------------------------------------
// SHA-256 block queue
// Short queue of full 64-byte blocks between the front end and the
// compression engine.
// ----------------------------------------------------------------------------
module shs_blkq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  shs_pkg::blk_t    push_blk,
    output logic             full,
    input  logic             pop,
    output shs_pkg::blk_t    pop_blk,
    output logic             empty
);
    import shs_pkg::*;

    localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

    blk_t               mem_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full    = (count_reg == CNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign pop_blk = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_blk;
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("block pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("block popped from an empty queue");

endmodule

### sv/shs_back.sv
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Runs one round a cycle over a popped block, folds the result into the
// chaining value and streams the digest out word by word after the last block.
// ----------------------------------------------------------------------------
module shs_back
(
    input  logic             clk,
    input  logic             rst_n,
    output logic             pop,
    input  shs_pkg::blk_t    pop_blk,
    input  logic             q_empty,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             m_tlast    // digest_last
);
    import shs_pkg::*;

    back_state_t    state_reg, state_next;
    logic [5:0]     round_reg;
    logic [2:0]     idx_reg;
    logic           msg_end_reg;
    logic [31:0]    h_reg [8];
    logic [31:0]    v_reg [8];
    logic [31:0]    w_reg [16];

    logic [31:0]    t1, t2, w_new, choose, major;
    logic           out_beat;

    assign choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1     = v_reg[7] + big_sigma1(v_reg[4]) + choose + ROUND_K[round_reg] + w_reg[0];
    assign t2     = big_sigma0(v_reg[0]) + major;
    assign w_new  = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                    state_next = B_ROUND;
            end
            B_ROUND:
            begin
                if (round_reg == BLK_END)
                    state_next = B_ADD;
            end
            B_ADD:
            begin
                state_next = msg_end_reg ? B_OUT : B_IDLE;
            end
            B_OUT:
            begin
                if (m_tready && idx_reg == WORD_END)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            B_IDLE:  pop      = !q_empty;
            B_OUT:   m_tvalid = 1'b1;
            default:
            begin
                pop      = 1'b0;
                m_tvalid = 1'b0;
            end
        endcase
    end

    assign out_beat = m_tvalid && m_tready;
    assign m_tdata  = {5'b0, idx_reg, h_reg[0]};
    assign m_tlast  = (idx_reg == WORD_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            round_reg <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= HASH_IV[i];
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_ROUND)
                round_reg <= round_reg + 6'd1;
            if (state_reg == B_ADD)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
            else if (out_beat)
            begin
                // rotate the digest out and the initial values in behind it
                for (int i = 0; i < 7; i++)
                    h_reg[i] <= h_reg[i + 1];
                h_reg[7] <= HASH_IV[idx_reg];
                idx_reg  <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            msg_end_reg <= pop_blk.msg_end;
            for (int i = 0; i < 16; i++)
                w_reg[i] <= pop_blk.data[BLK_BITS - 1 - 32 * i -: 32];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (state_reg == B_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
            v_reg[7]  <= v_reg[6];
            v_reg[6]  <= v_reg[5];
            v_reg[5]  <= v_reg[4];
            v_reg[4]  <= v_reg[3] + t1;
            v_reg[3]  <= v_reg[2];
            v_reg[2]  <= v_reg[1];
            v_reg[1]  <= v_reg[0];
            v_reg[0]  <= t1 + t2;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ROUND && round_reg == BLK_END) |=> (state_reg == B_ADD))
        else $error("compression did not stop after the last round");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && m_tlast) |=> (state_reg == B_IDLE && idx_reg == '0))
        else $error("digest output did not close after the eighth word");

endmodule

### sv/sha256_stream_hasher_core.sv
// Input: one beat a cycle while bytes are buffered; held off during end-of-message
// padding and when a block completes with the two-entry block queue full.
// End of message: the front end shifts in marker, zero fill and length bytes.
// Compression: per block a load, 64 rounds and the chaining add; this round
// loop sets sustained throughput. Digest: 8 output beats after the last block.
// Reset (rst_n low, asynchronous) empties the queue and loads the initial hash.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte stream in, eight big-endian digest words out per message.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic          s_tuser,   // [0] has_byte
    input  logic          s_tlast,   // is_last
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic          m_tlast    // digest_last
);
    import shs_pkg::*;

    logic   push, pop, q_full, q_empty;
    blk_t   push_blk, pop_blk;

    shs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .push     (push),
        .push_blk (push_blk),
        .q_full   (q_full)
    );

    shs_blkq u_blkq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_blk (push_blk),
        .full     (q_full),
        .pop      (pop),
        .pop_blk  (pop_blk),
        .empty    (q_empty)
    );

    shs_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_blk  (pop_blk),
        .q_empty  (q_empty),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
